// ----- rtl/taws_pkg.sv -----
// ----------------------------------------------------------------------------
// taws_pkg
// Shared widths, codes, register bundle and memory request type for the
// tiered action weight store.
// ----------------------------------------------------------------------------
package taws_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 21;
  localparam int TILE_W    = 20;
  localparam int TIER_W    = 21;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 4;
  localparam int SUM_DEPTH = 16;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;

  localparam int DEF_MAX_ACTS    = 16;
  localparam int DEF_TIER1_WORDS = 4096;
  localparam int DEF_TIER2_WORDS = 65536;
  localparam int DEF_TIER3_WORDS = 65536;

  localparam logic [CNT_W-1:0]  RST_ACTIONS_PER_TILE = 5'd16;
  localparam logic [TIER_W-1:0] RST_TIER1_END        = 21'd4096;
  localparam logic [TIER_W-1:0] RST_TIER2_END        = 21'd69632;
  localparam logic [TIER_W-1:0] RST_TIER3_END        = 21'd135168;

  typedef enum logic [1:0] {
    REG_ACTIONS_PER_TILE,
    REG_TIER1_END,
    REG_TIER2_END,
    REG_TIER3_END
  } reg_idx_t;

  typedef enum logic [1:0] {
    BANK_ONE,
    BANK_TWO,
    BANK_THREE,
    BANK_NONE
  } bank_t;

  typedef enum logic {
    OP_ACCUM,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]  actions_per_tile;
    logic [TIER_W-1:0] tier1_end;
    logic [TIER_W-1:0] tier2_end;
    logic [TIER_W-1:0] tier3_end;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- rtl/taws_ram.sv -----
// ----------------------------------------------------------------------------
// taws_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module taws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/taws_cfg.sv -----
// ----------------------------------------------------------------------------
// taws_cfg
// APB register file: action count and the three tier end indices.
// ----------------------------------------------------------------------------
module taws_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [taws_pkg::PADDR_W-1:0]  paddr,
  input  logic [taws_pkg::PDATA_W-1:0]  pwdata,
  output logic [taws_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output taws_pkg::cfg_t                cfg
);
  import taws_pkg::*;

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.actions_per_tile <= RST_ACTIONS_PER_TILE;
      cfg.tier1_end        <= RST_TIER1_END;
      cfg.tier2_end        <= RST_TIER2_END;
      cfg.tier3_end        <= RST_TIER3_END;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_ACTIONS_PER_TILE: cfg.actions_per_tile <= pwdata[CNT_W-1:0];
        REG_TIER1_END:        cfg.tier1_end        <= pwdata[TIER_W-1:0];
        REG_TIER2_END:        cfg.tier2_end        <= pwdata[TIER_W-1:0];
        REG_TIER3_END:        cfg.tier3_end        <= pwdata[TIER_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACTIONS_PER_TILE: prdata = PDATA_W'(cfg.actions_per_tile);
      REG_TIER1_END:        prdata = PDATA_W'(cfg.tier1_end);
      REG_TIER2_END:        prdata = PDATA_W'(cfg.tier2_end);
      REG_TIER3_END:        prdata = PDATA_W'(cfg.tier3_end);
    endcase
  end

endmodule

// ----- rtl/taws_engine.sv -----
// ----------------------------------------------------------------------------
// taws_engine
// Sequencer: clears the banks after reset, maps tiles to banks, streams
// weight reads into the per-action sums, performs read-modify-write updates
// and emits the sums through an output register.
// ----------------------------------------------------------------------------
module taws_engine #(
  parameter int MAX_ACTS    = taws_pkg::DEF_MAX_ACTS,
  parameter int TIER1_WORDS = taws_pkg::DEF_TIER1_WORDS,
  parameter int TIER2_WORDS = taws_pkg::DEF_TIER2_WORDS,
  parameter int TIER3_WORDS = taws_pkg::DEF_TIER3_WORDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  taws_pkg::cfg_t                 cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [taws_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [taws_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast,
  output taws_pkg::mem_req_t             mem_req,
  input  logic [taws_pkg::WORD_W-1:0]    rdata1,
  input  logic [taws_pkg::WORD_W-1:0]    rdata2,
  input  logic [taws_pkg::WORD_W-1:0]    rdata3
);
  import taws_pkg::*;

  localparam int CAP = (MAX_ACTS < SUM_DEPTH) ? MAX_ACTS : SUM_DEPTH;
  localparam int MAX_W12 = (TIER1_WORDS > TIER2_WORDS) ? TIER1_WORDS : TIER2_WORDS;
  localparam int MAX_WORDS = (MAX_W12 > TIER3_WORDS) ? MAX_W12 : TIER3_WORDS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_ACC,
    ST_DRAIN,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  op_t               op;
  logic [TILE_W-1:0] tile;
  logic [ACT_W-1:0]  chosen;
  logic [WORD_W-1:0] delta;
  logic              last;
  bank_t             bank;
  logic [ADDR_W-1:0] base;
  logic [ACT_W-1:0]  j;
  logic              p_vld;
  logic [ACT_W-1:0]  p_idx;
  logic              err;
  logic [WORD_W-1:0] sums [SUM_DEPTH];
  logic [ACT_W-1:0]  k;
  logic              out_vld;
  logic [WORD_W-1:0] out_value;
  logic [ACT_W-1:0]  out_act;
  logic              out_last;
  logic              out_stat;

  logic [CNT_W-1:0]  n_eff;
  logic [ACT_W-1:0]  n_last;
  logic              chosen_ok;
  bank_t             map_bank;
  logic [ADDR_W-1:0] map_base;
  logic [TIER_W-1:0] tile_x;
  logic [ADDR_W-1:0] words_sel;
  logic [ADDR_W-1:0] addr_calc;
  logic              addr_ok;
  logic [WORD_W-1:0] rdata_sel;

  always_comb begin
    if (cfg.actions_per_tile == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg.actions_per_tile > CNT_W'(CAP)) begin
      n_eff = CNT_W'(CAP);
    end else begin
      n_eff = cfg.actions_per_tile;
    end
  end

  assign n_last    = ACT_W'(n_eff - CNT_W'(1));
  assign chosen_ok = {1'b0, chosen} < n_eff;
  assign tile_x    = {1'b0, tile};

  always_comb begin
    if (tile_x < cfg.tier1_end) begin
      map_bank = BANK_ONE;
      map_base = tile_x;
    end else if (tile_x < cfg.tier2_end) begin
      map_bank = BANK_TWO;
      map_base = tile_x - cfg.tier1_end;
    end else if (tile_x < cfg.tier3_end) begin
      map_bank = BANK_THREE;
      map_base = tile_x - cfg.tier2_end;
    end else begin
      map_bank = BANK_NONE;
      map_base = '0;
    end
  end

  always_comb begin
    unique case (bank)
      BANK_ONE: begin
        words_sel = ADDR_W'(TIER1_WORDS);
        rdata_sel = rdata1;
      end
      BANK_TWO: begin
        words_sel = ADDR_W'(TIER2_WORDS);
        rdata_sel = rdata2;
      end
      BANK_THREE: begin
        words_sel = ADDR_W'(TIER3_WORDS);
        rdata_sel = rdata3;
      end
      BANK_NONE: begin
        words_sel = '0;
        rdata_sel = '0;
      end
    endcase
  end

  assign addr_calc = base + ADDR_W'(j);
  assign addr_ok   = addr_calc < words_sel;

  always_comb begin
    mem_req.we    = 3'b000;
    mem_req.addr  = addr_calc;
    mem_req.wdata = rdata_sel + delta;
    if (state == ST_CLEAR) begin
      mem_req.addr  = clr_cnt;
      mem_req.wdata = '0;
      mem_req.we[0] = clr_cnt < ADDR_W'(TIER1_WORDS);
      mem_req.we[1] = clr_cnt < ADDR_W'(TIER2_WORDS);
      mem_req.we[2] = clr_cnt < ADDR_W'(TIER3_WORDS);
    end else if (state == ST_UPD_WR) begin
      mem_req.we[0] = (bank == BANK_ONE);
      mem_req.we[1] = (bank == BANK_TWO);
      mem_req.we[2] = (bank == BANK_THREE);
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_vld;
  assign m_tdata  = {(M_TDATA_W - WORD_W - ACT_W)'(0), out_act, out_value};
  assign m_tuser  = out_stat;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      bank    <= BANK_NONE;
      j       <= '0;
      k       <= '0;
      p_vld   <= 1'b0;
      err     <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < SUM_DEPTH; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (out_vld && m_tready && state != ST_EMIT) begin
        out_vld <= 1'b0;
      end
      p_vld <= (state == ST_ACC) && addr_ok;
      if (p_vld) begin
        sums[p_idx] <= sums[p_idx] + rdata_sel;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == ADDR_W'(MAX_WORDS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op     <= op_t'(s_tuser);
            tile   <= s_tdata[TILE_W-1:0];
            chosen <= s_tdata[TILE_W+ACT_W-1:TILE_W];
            delta  <= s_tdata[TILE_W+ACT_W+WORD_W-1:TILE_W+ACT_W];
            last   <= s_tlast;
            state  <= ST_MAP;
          end
        end
        ST_MAP: begin
          bank <= map_bank;
          base <= map_base;
          if (map_bank == BANK_NONE) begin
            err <= 1'b1;
            if (op == OP_ACCUM && last) begin
              k     <= '0;
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end else if (op == OP_UPDATE) begin
            j     <= chosen;
            state <= ST_UPD_RD;
          end else begin
            j     <= '0;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!addr_ok) begin
            err <= 1'b1;
          end
          p_idx <= j;
          if (j == n_last) begin
            state <= ST_DRAIN;
          end else begin
            j <= j + ACT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (last) begin
            k     <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_UPD_RD: begin
          if (!addr_ok || !chosen_ok) begin
            err   <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_UPD_WR;
          end
        end
        ST_UPD_WR: begin
          state <= ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_vld || m_tready) begin
            out_vld   <= 1'b1;
            out_value <= sums[k];
            out_act   <= k;
            out_last  <= (k == n_last);
            out_stat  <= err;
            if (k == n_last) begin
              for (int i = 0; i < SUM_DEPTH; i++) begin
                sums[i] <= '0;
              end
              err   <= 1'b0;
              state <= ST_IDLE;
            end else begin
              k <= k + ACT_W'(1);
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/tiered_action_weight_store.sv -----
// ----------------------------------------------------------------------------
// tiered_action_weight_store
// Three-tier action weight store with per-action preference accumulation.
// ----------------------------------------------------------------------------
// After reset the block sweeps all three weight banks to zero, one word per
// cycle in each bank in parallel, up to the depth of the deepest bank (65536
// words at the default sizes); s_tready stays low during the sweep while the
// APB registers can be written. Each bank is a single-port RAM read one word
// per cycle. An accumulate beat reads n words, where n is the action count
// clamped to 1 .. min(MAX_ACTS, 16); an update beat reads the chosen word,
// then writes back the sum, and is dropped for a bad address or action. An
// accumulate beat with tlast set is followed by n result beats, one per cycle
// when m_tready stays high; the next input beat is taken while the final
// result waits in the output register.
// ----------------------------------------------------------------------------
module tiered_action_weight_store #(
  parameter int MAX_ACTS    = taws_pkg::DEF_MAX_ACTS,
  parameter int TIER1_WORDS = taws_pkg::DEF_TIER1_WORDS,
  parameter int TIER2_WORDS = taws_pkg::DEF_TIER2_WORDS,
  parameter int TIER3_WORDS = taws_pkg::DEF_TIER3_WORDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [taws_pkg::PADDR_W-1:0]   paddr,
  input  logic [taws_pkg::PDATA_W-1:0]   pwdata,
  output logic [taws_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tile_index[19:0], chosen_action[23:20], weight_delta[55:24]
  input  logic [taws_pkg::S_TDATA_W-1:0] s_tdata,
  // operation: 0 accumulate, 1 update
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pref_value[31:0], pref_action[35:32], zero[39:36]
  output logic [taws_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import taws_pkg::*;

  localparam int AW1 = (TIER1_WORDS > 1) ? $clog2(TIER1_WORDS) : 1;
  localparam int AW2 = (TIER2_WORDS > 1) ? $clog2(TIER2_WORDS) : 1;
  localparam int AW3 = (TIER3_WORDS > 1) ? $clog2(TIER3_WORDS) : 1;

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata1;
  logic [WORD_W-1:0] rdata2;
  logic [WORD_W-1:0] rdata3;

  taws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  taws_engine #(
    .MAX_ACTS    (MAX_ACTS),
    .TIER1_WORDS (TIER1_WORDS),
    .TIER2_WORDS (TIER2_WORDS),
    .TIER3_WORDS (TIER3_WORDS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .mem_req  (mem_req),
    .rdata1   (rdata1),
    .rdata2   (rdata2),
    .rdata3   (rdata3)
  );

  taws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TIER1_WORDS)
  ) u_bank1 (
    .clk   (clk),
    .we    (mem_req.we[0]),
    .addr  (mem_req.addr[AW1-1:0]),
    .wdata (mem_req.wdata),
    .rdata (rdata1)
  );

  taws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TIER2_WORDS)
  ) u_bank2 (
    .clk   (clk),
    .we    (mem_req.we[1]),
    .addr  (mem_req.addr[AW2-1:0]),
    .wdata (mem_req.wdata),
    .rdata (rdata2)
  );

  taws_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TIER3_WORDS)
  ) u_bank3 (
    .clk   (clk),
    .we    (mem_req.we[2]),
    .addr  (mem_req.addr[AW3-1:0]),
    .wdata (mem_req.wdata),
    .rdata (rdata3)
  );

endmodule

// ----- rtl/taws_check.sv -----
// ----------------------------------------------------------------------------
// taws_check
// Port-level checks for the tiered action weight store, bound to the top.
// ----------------------------------------------------------------------------
module taws_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [taws_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import taws_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat shown after reset");

  // advance the action number and keep the status within a run
  a_run_seq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
      m_tdata[35:32] == 4'($past(m_tdata[35:32]) + 4'd1)
      && m_tuser == $past(m_tuser))
    else $error("result run out of sequence");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while one is in work");

endmodule

bind tiered_action_weight_store taws_check u_check (.*);
